FILE: hw/rtl/mdm_pkg.sv
// Shared types and constants for the mecanum drive mixer.
package mdm_pkg;

    localparam int IN_W   = 16;
    localparam int CFG_W  = 15;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int LANES  = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FWD_DB    = 3'd0;
    localparam logic [2:0] REG_STR_DB    = 3'd1;
    localparam logic [2:0] REG_STR_SNAP  = 3'd2;
    localparam logic [2:0] REG_TW_DB     = 3'd3;
    localparam logic [2:0] REG_TW_CLAMP  = 3'd4;

    // wheel lanes: front left, front right, rear left, rear right
    localparam logic [LANES-1:0] NEG_LANES = 4'b1010;

    typedef struct packed {
        logic [CFG_W-1:0] fwd_db;
        logic [CFG_W-1:0] str_db;
        logic [CFG_W-1:0] str_snap;
        logic [CFG_W-1:0] tw_db;
        logic [CFG_W-1:0] tw_clamp;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fwd_db:   15'd4915,
        str_db:   15'd11469,
        str_snap: 15'd14746,
        tw_db:    15'd2458,
        tw_clamp: 15'd11469
    };

endpackage

FILE: hw/rtl/mdm_shape.sv
// Axis shaping: deadbands, strafe snap, twist scale and clamp.
module mdm_shape #(
    parameter int FRAC_BITS = 14
) (
    input  mdm_pkg::cfg_t                   cfg,
    input  logic signed [mdm_pkg::IN_W-1:0] x,
    input  logic signed [mdm_pkg::IN_W-1:0] y,
    input  logic signed [mdm_pkg::IN_W-1:0] z,
    output logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16):0] fwd,
    output logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16):0] strafe,
    output logic signed [((FRAC_BITS > 16) ? FRAC_BITS : 16):0] rot,
    output logic                             stationary
);

    localparam int MB = (FRAC_BITS > 16) ? FRAC_BITS : 16;
    localparam int SB = MB + 1;
    localparam logic [63:0] SNAP = (64'd9 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

    logic [15:0]          ax;
    logic [15:0]          ay;
    logic [15:0]          az;
    logic signed [SB-1:0] snap_v;
    logic signed [SB-1:0] x_ext;
    logic signed [SB-1:0] y_ext;
    logic signed [SB-1:0] tc;
    logic signed [17:0]   z18;
    logic signed [17:0]   z3;
    logic signed [17:0]   rq;
    logic                 x_pos;

    assign ax     = x[15] ? (~x + 16'd1) : x;
    assign ay     = y[15] ? (~y + 16'd1) : y;
    assign az     = z[15] ? (~z + 16'd1) : z;
    assign snap_v = SNAP[SB-1:0];
    assign x_ext  = {{(SB-16){x[15]}}, x};
    assign y_ext  = {{(SB-16){y[15]}}, y};
    assign tc     = {{(SB-15){1'b0}}, cfg.tw_clamp};
    assign x_pos  = !x[15] && (x != 16'sd0);

    // 3z/4, truncated toward zero
    assign z18 = {{2{z[15]}}, z};
    assign z3  = z18 + (z18 <<< 1);
    assign rq  = z3[17] ? ((z3 + 18'sd3) >>> 2) : (z3 >>> 2);

    always_comb
    begin
        if (ay < {1'b0, cfg.fwd_db})
        begin
            fwd = '0;
        end
        else
        begin
            fwd = -y_ext;
        end

        if (ax < {1'b0, cfg.str_db})
        begin
            strafe = '0;
        end
        else if (ax < {1'b0, cfg.str_snap})
        begin
            strafe = x_pos ? -snap_v : snap_v;
        end
        else
        begin
            strafe = -x_ext;
        end

        rot = {{(SB-16){rq[15]}}, rq[15:0]};
        if (az > {1'b0, cfg.tw_clamp})
        begin
            rot = z[15] ? -tc : tc;
        end
        // deadband wins over the clamp
        if (az < {1'b0, cfg.tw_db})
        begin
            rot = '0;
        end
    end

    assign stationary = (fwd == '0) && (strafe == '0) && (rot == '0);

endmodule

FILE: hw/rtl/mdm_div_step.sv
// One restoring-division step: compare and conditional subtract.
module mdm_div_step #(
    parameter int WM = 18
) (
    input  logic [WM:0]   t,
    input  logic [WM-1:0] dvs,
    output logic          q_bit,
    output logic [WM-1:0] rem
);

    logic [WM:0] diff;

    assign diff  = t - {1'b0, dvs};
    assign q_bit = (t >= {1'b0, dvs});
    assign rem   = q_bit ? diff[WM-1:0] : t[WM-1:0];

endmodule

FILE: hw/rtl/mecanum_drive_mixer_top.sv
// Mecanum wheel mixer: shaping, mixing, normalize by the largest wheel, output.
// Throughput: one beat per cycle while out_stall is low; the quotient is built one
// bit per stage across FRAC_BITS+2 divider stages, four wheels side by side.
// Stall propagates stage by stage, so empty stages still take beats.
// Reset: pipeline empties and the five config registers return to their defaults.
module mecanum_drive_mixer_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mdm_pkg::ADDR_W-1:0]    paddr,
    input  logic [mdm_pkg::DATA_W-1:0]    pwdata,
    output logic [mdm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [mdm_pkg::IN_W-1:0] stick_x,
    input  logic signed [mdm_pkg::IN_W-1:0] stick_y,
    input  logic signed [mdm_pkg::IN_W-1:0] stick_twist,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            front_left_cmd,
    output logic signed [15:0]            front_right_cmd,
    output logic signed [15:0]            rear_left_cmd,
    output logic signed [15:0]            rear_right_cmd,
    output logic                          stationary
);

    localparam int MB = (FRAC_BITS > 16) ? FRAC_BITS : 16;
    localparam int SB = MB + 1;
    localparam int WM = MB + 2;
    localparam int WS = MB + 3;
    localparam int ND = FRAC_BITS + 2;
    localparam int NS = ND + 4;
    localparam int L  = mdm_pkg::LANES;
    localparam logic [WM-1:0] ONE     = {{(WM-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [WM-1:0] LIM_POS = WM'(32767);
    localparam logic [WM-1:0] LIM_NEG = WM'(32768);

    // ---------------- config port ----------------
    mdm_pkg::cfg_t cfg_reg;
    mdm_pkg::cfg_t cfg_next;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                mdm_pkg::REG_FWD_DB:   cfg_next.fwd_db   = pwdata[14:0];
                mdm_pkg::REG_STR_DB:   cfg_next.str_db   = pwdata[14:0];
                mdm_pkg::REG_STR_SNAP: cfg_next.str_snap = pwdata[14:0];
                mdm_pkg::REG_TW_DB:    cfg_next.tw_db    = pwdata[14:0];
                mdm_pkg::REG_TW_CLAMP: cfg_next.tw_clamp = pwdata[14:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            mdm_pkg::REG_FWD_DB:   prdata = {17'd0, cfg_reg.fwd_db};
            mdm_pkg::REG_STR_DB:   prdata = {17'd0, cfg_reg.str_db};
            mdm_pkg::REG_STR_SNAP: prdata = {17'd0, cfg_reg.str_snap};
            mdm_pkg::REG_TW_DB:    prdata = {17'd0, cfg_reg.tw_db};
            mdm_pkg::REG_TW_CLAMP: prdata = {17'd0, cfg_reg.tw_clamp};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= mdm_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- pipeline control ----------------
    // stages: 0 shape, 1 mix, 2 max, 3..ND+2 divide, NS-1 output
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   adv;

    assign adv[NS] = !out_stall;
    for (genvar i = 0; i < NS; i++)
    begin : g_adv
        assign adv[i] = !valid_reg[i] || adv[i+1];
    end

    assign valid_next = {valid_reg[NS-2:0], in_valid};
    assign in_stall   = !adv[0];
    assign out_valid  = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // ---------------- stage 0: shaping ----------------
    logic signed [SB-1:0] fwd_c;
    logic signed [SB-1:0] strafe_c;
    logic signed [SB-1:0] rot_c;
    logic                 stat_c;
    logic signed [SB-1:0] fwd_reg;
    logic signed [SB-1:0] strafe_reg;
    logic signed [SB-1:0] rot_reg;
    logic                 stat0_reg;

    mdm_shape #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shape (
        .cfg        (cfg_reg),
        .x          (stick_x),
        .y          (stick_y),
        .z          (stick_twist),
        .fwd        (fwd_c),
        .strafe     (strafe_c),
        .rot        (rot_c),
        .stationary (stat_c)
    );

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            fwd_reg    <= fwd_c;
            strafe_reg <= strafe_c;
            rot_reg    <= rot_c;
            stat0_reg  <= stat_c;
        end
    end

    // ---------------- stage 1: mixing ----------------
    logic signed [WS-1:0] f_e;
    logic signed [WS-1:0] s_e;
    logic signed [WS-1:0] r_e;
    logic signed [WS-1:0] w_c [L];
    logic signed [WS-1:0] wneg_c [L];
    logic [L-1:0]         sgn1_reg;
    logic [WM-1:0]        mag1_reg [L];
    logic                 stat1_reg;

    assign f_e = {{2{fwd_reg[SB-1]}}, fwd_reg};
    assign s_e = {{2{strafe_reg[SB-1]}}, strafe_reg};
    assign r_e = {{2{rot_reg[SB-1]}}, rot_reg};

    assign w_c[0] = f_e - r_e + s_e;
    assign w_c[1] = f_e + r_e - s_e;
    assign w_c[2] = f_e - r_e - s_e;
    assign w_c[3] = f_e + r_e + s_e;

    for (genvar l = 0; l < L; l++)
    begin : g_neg
        assign wneg_c[l] = -w_c[l];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int l = 0; l < L; l++)
            begin
                sgn1_reg[l] <= w_c[l][WS-1];
                mag1_reg[l] <= w_c[l][WS-1] ? wneg_c[l][WM-1:0] : w_c[l][WM-1:0];
            end
            stat1_reg <= stat0_reg;
        end
    end

    // ---------------- stage 2: largest magnitude ----------------
    logic [WM-1:0] m01_c;
    logic [WM-1:0] m23_c;
    logic [WM-1:0] mx_c;
    logic [L-1:0]  sgn2_reg;
    logic [WM-1:0] mag2_reg [L];
    logic [WM-1:0] m2_reg;
    logic          scale2_reg;
    logic          stat2_reg;

    assign m01_c = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
    assign m23_c = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
    assign mx_c  = (m01_c > m23_c) ? m01_c : m23_c;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sgn2_reg   <= sgn1_reg;
            mag2_reg   <= mag1_reg;
            m2_reg     <= mx_c;
            scale2_reg <= (mx_c > ONE);
            stat2_reg  <= stat1_reg;
        end
    end

    // ---------------- stages 3..: divide |w| * 2^(F+1) / M ----------------
    // rounded quotient = (q' + 1) >> 1, which matches round-half-up of |w|*ONE/M
    logic [L-1:0]  dsgn_reg   [ND];
    logic [WM-1:0] dmag_reg   [ND][L];
    logic [WM-1:0] dm_reg     [ND];
    logic [ND-1:0] dscale_reg;
    logic [ND-1:0] dstat_reg;
    logic [WM-1:0] rem_reg    [ND][L];
    logic [ND-1:0] quo_reg    [ND][L];

    for (genvar k = 0; k < ND; k++)
    begin : g_div
        logic [L-1:0]  src_sgn;
        logic [WM-1:0] src_mag [L];
        logic [WM-1:0] src_m;
        logic          src_scale;
        logic          src_stat;
        logic [ND-1:0] src_quo [L];
        logic [WM:0]   t_c     [L];
        logic [L-1:0]  bit_c;
        logic [WM-1:0] rem_c   [L];

        if (k == 0)
        begin : g_first
            assign src_sgn   = sgn2_reg;
            assign src_mag   = mag2_reg;
            assign src_m     = m2_reg;
            assign src_scale = scale2_reg;
            assign src_stat  = stat2_reg;
            for (genvar l = 0; l < L; l++)
            begin : g_l
                assign src_quo[l] = '0;
                assign t_c[l]     = {1'b0, mag2_reg[l]};
            end
        end
        else
        begin : g_rest
            assign src_sgn   = dsgn_reg[k-1];
            assign src_mag   = dmag_reg[k-1];
            assign src_m     = dm_reg[k-1];
            assign src_scale = dscale_reg[k-1];
            assign src_stat  = dstat_reg[k-1];
            for (genvar l = 0; l < L; l++)
            begin : g_l
                assign src_quo[l] = quo_reg[k-1][l];
                assign t_c[l]     = {rem_reg[k-1][l], 1'b0};
            end
        end

        for (genvar l = 0; l < L; l++)
        begin : g_lane
            mdm_div_step #(
                .WM (WM)
            ) u_step (
                .t     (t_c[l]),
                .dvs   (src_m),
                .q_bit (bit_c[l]),
                .rem   (rem_c[l])
            );
        end

        always_ff @(posedge clk)
        begin
            if (adv[3+k])
            begin
                dsgn_reg[k]   <= src_sgn;
                dmag_reg[k]   <= src_mag;
                dm_reg[k]     <= src_m;
                dscale_reg[k] <= src_scale;
                dstat_reg[k]  <= src_stat;
                for (int l = 0; l < L; l++)
                begin
                    rem_reg[k][l] <= rem_c[l];
                    quo_reg[k][l] <= {src_quo[l][ND-2:0], bit_c[l]};
                end
            end
        end
    end

    // ---------------- output stage: round, polarity, saturate ----------------
    logic [ND-1:0]        qr_c   [L];
    logic [WM-1:0]        rmag_c [L];
    logic [L-1:0]         neg_c;
    logic signed [15:0]   cmd_c  [L];
    logic signed [15:0]   cmd_reg [L];
    logic                 stat_out_reg;

    for (genvar l = 0; l < L; l++)
    begin : g_out
        assign qr_c[l]   = quo_reg[ND-1][l] + ND'(1);
        assign rmag_c[l] = dscale_reg[ND-1]
                         ? {{(WM-ND+1){1'b0}}, qr_c[l][ND-1:1]}
                         : dmag_reg[ND-1][l];
        assign neg_c[l]  = dsgn_reg[ND-1][l] ^ mdm_pkg::NEG_LANES[l];
        assign cmd_c[l]  = neg_c[l]
                         ? ((rmag_c[l] >= LIM_NEG) ? 16'sh8000 : (16'd0 - rmag_c[l][15:0]))
                         : ((rmag_c[l] >= LIM_POS) ? 16'sh7FFF : rmag_c[l][15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            cmd_reg      <= cmd_c;
            stat_out_reg <= dstat_reg[ND-1];
        end
    end

    assign front_left_cmd  = cmd_reg[0];
    assign front_right_cmd = cmd_reg[1];
    assign rear_left_cmd   = cmd_reg[2];
    assign rear_right_cmd  = cmd_reg[3];
    assign stationary      = stat_out_reg;

endmodule

FILE: tb/wheel_cmd_monitor.sv
// Watches the config port and both stream channels, predicts wheel commands, counts mismatches.
`timescale 1ns / 1ps

module wheel_cmd_monitor
    import mdm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [IN_W-1:0]   stick_x,
    input  logic signed [IN_W-1:0]   stick_y,
    input  logic signed [IN_W-1:0]   stick_twist,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [15:0]       front_left_cmd,
    input  logic signed [15:0]       front_right_cmd,
    input  logic signed [15:0]       rear_left_cmd,
    input  logic signed [15:0]       rear_right_cmd,
    input  logic                     stationary,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic signed [15:0] rl;
        logic signed [15:0] rr;
        logic               still;
    } wheel_cmd_t;

    cfg_t       thresholds;
    wheel_cmd_t wheel_cmd_q[$];
    wheel_cmd_t want;

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic wheel_cmd_t mix_wheels(input logic signed [15:0] sx,
                                              input logic signed [15:0] sy,
                                              input logic signed [15:0] sz,
                                              input cfg_t c);
        longint one, snap, x, y, z, fwd, strafe, rot, peak, q;
        longint lane [4];
        logic signed [15:0] cmd [4];
        wheel_cmd_t r;
        one  = longint'(1) << FRAC_BITS;
        snap = (9 * one + 5) / 10;
        x = sx;
        y = sy;
        z = sz;

        fwd = (mag64(y) < longint'(c.fwd_db)) ? 0 : -y;

        if (mag64(x) < longint'(c.str_db))
            strafe = 0;
        else if (mag64(x) < longint'(c.str_snap))
            strafe = (x > 0) ? -snap : snap;
        else
            strafe = -x;

        // clamp first, deadband last so it wins
        rot = (3 * z) / 4;
        if (mag64(z) > longint'(c.tw_clamp))
            rot = (z > 0) ? longint'(c.tw_clamp) : -longint'(c.tw_clamp);
        if (mag64(z) < longint'(c.tw_db))
            rot = 0;

        lane[0] = fwd - rot + strafe;
        lane[1] = fwd + rot - strafe;
        lane[2] = fwd - rot - strafe;
        lane[3] = fwd + rot + strafe;

        peak = 0;
        for (int i = 0; i < LANES; i++)
            if (mag64(lane[i]) > peak)
                peak = mag64(lane[i]);

        for (int i = 0; i < LANES; i++)
        begin
            if (peak > one)
            begin
                q = (mag64(lane[i]) * one + peak / 2) / peak;
                lane[i] = (lane[i] < 0) ? -q : q;
            end
            if (NEG_LANES[i])
                lane[i] = -lane[i];
            if (lane[i] > 32767)
                lane[i] = 32767;
            if (lane[i] < -32768)
                lane[i] = -32768;
            cmd[i] = lane[i][15:0];
        end

        r.fl    = cmd[0];
        r.fr    = cmd[1];
        r.rl    = cmd[2];
        r.rr    = cmd[3];
        r.still = (fwd == 0 && strafe == 0 && rot == 0);
        return r;
    endfunction

    task automatic check_lane(input string lane_name, input logic signed [15:0] exp_v,
                              input logic signed [15:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, lane_name, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds = CFG_RESET;
            wheel_cmd_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_FWD_DB:   thresholds.fwd_db   = pwdata[CFG_W-1:0];
                    REG_STR_DB:   thresholds.str_db   = pwdata[CFG_W-1:0];
                    REG_STR_SNAP: thresholds.str_snap = pwdata[CFG_W-1:0];
                    REG_TW_DB:    thresholds.tw_db    = pwdata[CFG_W-1:0];
                    REG_TW_CLAMP: thresholds.tw_clamp = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid === 1'b1 && in_stall === 1'b0)
                wheel_cmd_q.push_back(mix_wheels(stick_x, stick_y, stick_twist, thresholds));

            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (wheel_cmd_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: output beat with nothing expected: fl %0d fr %0d rl %0d rr %0d",
                             $time, front_left_cmd, front_right_cmd, rear_left_cmd,
                             rear_right_cmd);
                end
                else
                begin
                    want = wheel_cmd_q.pop_front();
                    check_lane("front_left_cmd", want.fl, front_left_cmd);
                    check_lane("front_right_cmd", want.fr, front_right_cmd);
                    check_lane("rear_left_cmd", want.rl, rear_left_cmd);
                    check_lane("rear_right_cmd", want.rr, rear_right_cmd);
                    check_lane("stationary", {15'd0, want.still}, {15'd0, stationary});
                end
            end

            pending <= wheel_cmd_q.size();
        end
    end

endmodule

FILE: tb/tb_mecanum_drive_mixer_top.sv
// Stimulus, stalls and verdict for the mecanum drive mixer.
`timescale 1ns / 1ps

module tb_mecanum_drive_mixer_top;
    import mdm_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int SETTLE      = FRAC_BITS + 5 + 8;
    localparam int HOLD_CYCLES = 100;
    localparam int LIMIT       = 500000;
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [IN_W-1:0] stick_x;
    logic signed [IN_W-1:0] stick_y;
    logic signed [IN_W-1:0] stick_twist;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [15:0]     front_left_cmd;
    logic signed [15:0]     front_right_cmd;
    logic signed [15:0]     rear_left_cmd;
    logic signed [15:0]     rear_right_cmd;
    logic                   stationary;

    int   errors;
    int   pending;
    int   cycle_count;
    int   tx_mode;
    int   rx_mode;
    logic hold_go;
    int   cfg_val [8];

    mecanum_drive_mixer_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .stick_x         (stick_x),
        .stick_y         (stick_y),
        .stick_twist     (stick_twist),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .front_left_cmd  (front_left_cmd),
        .front_right_cmd (front_right_cmd),
        .rear_left_cmd   (rear_left_cmd),
        .rear_right_cmd  (rear_right_cmd),
        .stationary      (stationary)
    );

    wheel_cmd_monitor #(
        .FRAC_BITS(FRAC_BITS)
    ) wheel_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .stick_x         (stick_x),
        .stick_y         (stick_y),
        .stick_twist     (stick_twist),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .front_left_cmd  (front_left_cmd),
        .front_right_cmd (front_right_cmd),
        .rear_left_cmd   (rear_left_cmd),
        .rear_right_cmd  (rear_right_cmd),
        .stationary      (stationary),
        .errors          (errors),
        .pending         (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // one axis value: plain range, near a threshold, raw bits, or an extreme
    function automatic logic signed [15:0] axis_value(input int thr_a, input int thr_b);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            v = int'($urandom_range(0, 32768)) - 16384;
        else if (pick < 75)
        begin
            v = (($urandom_range(0, 1) != 0) ? thr_a : thr_b) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) != 0)
                v = -v;
        end
        else if (pick < 85)
            v = $urandom;
        else
        begin
            case ($urandom_range(0, 5))
                0: v = 16384;
                1: v = -16384;
                2: v = 32767;
                3: v = -32768;
                default: v = 0;
            endcase
        end
        return v[15:0];
    endfunction

    function automatic int threshold_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 16384);
        if (pick < 85)
            return ($urandom_range(0, 1) != 0) ? 16384 : 0;
        return $urandom_range(0, 32767);
    endfunction

    task automatic send_beat(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
        in_valid    <= 1'b1;
        stick_x     <= x;
        stick_y     <= y;
        stick_twist <= z;
        do
            @(negedge clk);
        while (in_stall !== 1'b0);
        @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid    <= 1'b0;
            stick_x     <= $urandom;
            stick_y     <= $urandom;
            stick_twist <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic sender_pause();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_mode == 0 || pick < 55)
            return;
        if (pick < 90)
            idle_gap($urandom_range(1, 3));
        else
            idle_gap($urandom_range(6, 30));
    endtask

    task automatic drive_stick(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z);
        send_beat(x, y, z);
        sender_pause();
    endtask

    task automatic run_random(input int n);
        logic signed [15:0] x, y, z;
        repeat (n)
        begin
            x = axis_value(cfg_val[REG_STR_DB], cfg_val[REG_STR_SNAP]);
            y = axis_value(cfg_val[REG_FWD_DB], cfg_val[REG_FWD_DB]);
            z = axis_value(cfg_val[REG_TW_DB], cfg_val[REG_TW_CLAMP]);
            drive_stick(x, y, z);
        end
    endtask

    // stop sending and let the pipeline run dry
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper bits are junk, only the low field width is kept
        pwdata  <= ($urandom & 32'hFFFF8000) | (value & 32'h7FFF);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (pready !== 1'b1);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_val[idx] = value & 32'h7FFF;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input int fwd_db, input int str_db, input int str_snap,
                                  input int tw_db, input int tw_clamp);
        cfg_write(REG_FWD_DB, fwd_db);
        cfg_write(REG_STR_DB, str_db);
        cfg_write(REG_STR_SNAP, str_snap);
        cfg_write(REG_TW_DB, tw_db);
        cfg_write(REG_TW_CLAMP, tw_clamp);
    endtask

    // receiver: random stall runs, plus one long hold-off on request
    initial
    begin : rx_side
        int  run_left;
        int  hold_left;
        bit  hold_taken;
        bit  stall_now;
        out_stall  = 1'b0;
        run_left   = 0;
        hold_left  = 0;
        hold_taken = 0;
        stall_now  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_mode == 0)
                out_stall <= 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    stall_now = ($urandom_range(0, 99) < 30);
                    run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                            : $urandom_range(1, 4);
                end
                run_left--;
                out_stall <= stall_now;
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        stick_x     = '0;
        stick_y     = '0;
        stick_twist = '0;
        hold_go     = 1'b0;
        tx_mode     = 1;
        rx_mode     = 1;
        foreach (cfg_val[i])
            cfg_val[i] = 0;
        cfg_val[REG_FWD_DB]   = CFG_RESET.fwd_db;
        cfg_val[REG_STR_DB]   = CFG_RESET.str_db;
        cfg_val[REG_STR_SNAP] = CFG_RESET.str_snap;
        cfg_val[REG_TW_DB]    = CFG_RESET.tw_db;
        cfg_val[REG_TW_CLAMP] = CFG_RESET.tw_clamp;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, default thresholds
        drive_stick(16'sd0, 16'sd0, 16'sd0);
        drive_stick(16'sd0, -16'sd16384, 16'sd0);
        drive_stick(16'sd0, 16'sd16384, 16'sd0);
        drive_stick(16'sd0, 16'sd4914, 16'sd0);
        drive_stick(16'sd0, -16'sd4915, 16'sd0);
        drive_stick(16'sd11468, 16'sd0, 16'sd0);
        drive_stick(16'sd11469, 16'sd0, 16'sd0);
        drive_stick(-16'sd14745, 16'sd0, 16'sd0);
        drive_stick(16'sd14746, 16'sd0, 16'sd0);
        drive_stick(-16'sd16384, 16'sd0, 16'sd0);
        drive_stick(16'sd0, 16'sd0, 16'sd2457);
        drive_stick(16'sd0, 16'sd0, 16'sd2458);
        drive_stick(16'sd0, 16'sd0, -16'sd11469);
        drive_stick(16'sd0, 16'sd0, 16'sd11470);
        drive_stick(16'sd0, 16'sd0, -16'sd16384);
        drive_stick(16'sd16384, -16'sd16384, 16'sd16384);
        drive_stick(-16'sd16384, 16'sd16384, -16'sd16384);
        drive_stick(16'sd32767, 16'sd32767, 16'sd32767);
        drive_stick(-16'sd32768, -16'sd32768, -16'sd32768);
        drive_stick(-16'sd32768, 16'sd0, 16'sd32767);
        drive_stick(16'sd12000, -16'sd8000, 16'sd5000);
        drive_stick(-16'sd3, 16'sd3, -16'sd3);
        drive_stick(16'sd16384, 16'sd0, 16'sd16384);
        drive_stick(16'sd0, -16'sd16384, -16'sd16384);

        run_random(30);
        // output held off while input keeps coming: pipeline must back up
        hold_go <= 1'b1;
        tx_mode = 0;
        run_random(50);
        tx_mode = 1;
        run_random(40);

        // all thresholds zero, plus a write to an unused index
        wait_idle();
        set_thresholds(0, 0, 0, 0, 0);
        cfg_write(REG_SPARE, 16'h1234);
        tx_mode = 0;
        rx_mode = 0;
        drive_stick(16'sd0, 16'sd0, 16'sd0);
        drive_stick(16'sd1, 16'sd0, 16'sd0);
        drive_stick(-16'sd1, -16'sd1, -16'sd1);
        run_random(60);

        wait_idle();
        tx_mode = 1;
        rx_mode = 1;
        set_thresholds(16384, 16384, 16384, 16384, 16384);
        run_random(60);

        // snap band empty: snap limit below the strafe deadband
        wait_idle();
        set_thresholds(100, 12000, 8000, 0, 16384);
        run_random(60);

        wait_idle();
        set_thresholds(32767, 32767, 32767, 32767, 32767);
        run_random(30);

        repeat (4)
        begin
            wait_idle();
            set_thresholds(threshold_value(), threshold_value(), threshold_value(),
                           threshold_value(), threshold_value());
            run_random(60);
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
